[src/mba_pkg.sv]
// Shared types and constants of the mosaic block averager.
package mba_pkg;

    localparam int MAX_BLOCKS_ACROSS = 1024;
    localparam int MAX_FRAME_SIDE    = 4096;

    localparam int DIM_W   = 13;
    localparam int SUM_W   = 32;
    localparam int CNT_W   = 26;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 12;
    localparam int PIX_W   = 8;
    localparam int IDX_W   = 2;
    localparam int BLOCKS_DOWN_MAX = 4096;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_BLOCKS_ACROSS = 2'd2;
    localparam logic [IDX_W-1:0] REG_BLOCKS_DOWN   = 2'd3;

    localparam logic [12:0] RST_FRAME_WIDTH   = 13'd640;
    localparam logic [12:0] RST_FRAME_HEIGHT  = 13'd480;
    localparam logic [10:0] RST_BLOCKS_ACROSS = 11'd40;
    localparam logic [12:0] RST_BLOCKS_DOWN   = 13'd30;

    typedef struct packed {
        logic [COL_W-1:0] block_col;
        logic [ROW_W-1:0] block_row;
        logic [SUM_W-1:0] sum_red;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_blue;
        logic [CNT_W-1:0] count;
        logic             frame_done;
    } cell_t;

    typedef enum logic [2:0] {
        F_PIX  = 3'b001,
        F_DIV  = 3'b010,
        F_SUM  = 3'b100
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_OUT  = 3'b100
    } back_state_t;

endpackage

[src/mba_if.sv]
// Channel interfaces: pixel input, cell result output, configuration write.
interface mba_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    modport source (output valid, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface mba_res_if;
    logic        valid;
    logic        ready;
    logic [9:0]  block_col;
    logic [11:0] block_row;
    logic [7:0]  avg_red;
    logic [7:0]  avg_green;
    logic [7:0]  avg_blue;
    logic        frame_done;
    modport source (output valid, block_col, block_row, avg_red, avg_green, avg_blue,
                    frame_done, input ready);
    modport sink   (input valid, block_col, block_row, avg_red, avg_green, avg_blue,
                    frame_done, output ready);
endinterface

interface mba_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [12:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/mba_front.sv]
// Front end: config registers, frame latch, raster counters, column sum memory.
module mba_front
    import mba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mba_pix_if.sink    pix,
    mba_cfg_if.sink    cfg,
    output cell_t      cell_data,
    output logic       cell_valid,
    input  logic       cell_ready
);

    localparam int AW = (MAX_BLOCKS_ACROSS > 1) ? $clog2(MAX_BLOCKS_ACROSS) : 1;

    logic [12:0] fw_cfg_reg, fh_cfg_reg, bd_cfg_reg;
    logic [10:0] ba_cfg_reg;
    logic [12:0] fw_c, fh_c, bd_c;
    logic [10:0] ba_c;

    front_state_t state_reg;
    logic        latched_reg;
    logic [3:0]  step_reg;
    logic [12:0] qw_reg, qh_reg, rw_reg, rh_reg, dw_reg, dh_reg;
    logic [13:0] tw, th;
    logic [12:0] lat_fw_reg, lat_fh_reg, lat_cols_reg, lat_rows_reg;
    logic [12:0] cell_w_reg, cell_h_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [12:0] x_reg, y_reg, cx_reg, cy_reg, bx_reg, by_reg;
    logic        start, accept, active;

    logic [3*SUM_W-1:0] mem [MAX_BLOCKS_ACROSS];
    logic [3*SUM_W-1:0] rd_reg;
    logic [AW-1:0]      addr_reg;
    logic [3*PIX_W-1:0] px_reg;
    logic               first_reg, last_reg, done_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [SUM_W-1:0]   s_r, s_g, s_b;
    logic               wr_en;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_cfg_reg <= RST_FRAME_WIDTH;
            fh_cfg_reg <= RST_FRAME_HEIGHT;
            ba_cfg_reg <= RST_BLOCKS_ACROSS;
            bd_cfg_reg <= RST_BLOCKS_DOWN;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_FRAME_WIDTH:   fw_cfg_reg <= cfg.data;
                REG_FRAME_HEIGHT:  fh_cfg_reg <= cfg.data;
                REG_BLOCKS_ACROSS: ba_cfg_reg <= cfg.data[10:0];
                REG_BLOCKS_DOWN:   bd_cfg_reg <= cfg.data;
                default:           bd_cfg_reg <= bd_cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        fw_c = (fw_cfg_reg == 13'd0) ? 13'd1 :
               (fw_cfg_reg > MAX_FRAME_SIDE) ? 13'(MAX_FRAME_SIDE) : fw_cfg_reg;
        fh_c = (fh_cfg_reg == 13'd0) ? 13'd1 :
               (fh_cfg_reg > MAX_FRAME_SIDE) ? 13'(MAX_FRAME_SIDE) : fh_cfg_reg;
        ba_c = (ba_cfg_reg == 11'd0) ? 11'd1 :
               (ba_cfg_reg > MAX_BLOCKS_ACROSS) ? 11'(MAX_BLOCKS_ACROSS) : ba_cfg_reg;
        bd_c = (bd_cfg_reg == 13'd0) ? 13'd1 :
               (bd_cfg_reg > BLOCKS_DOWN_MAX) ? 13'(BLOCKS_DOWN_MAX) : bd_cfg_reg;
    end

    assign start  = (x_reg == 13'd0) && (y_reg == 13'd0);
    assign pix.ready = (state_reg == F_PIX) && !(start && !latched_reg);
    assign accept = pix.valid && pix.ready;
    assign active = (bx_reg < lat_cols_reg) && (by_reg < lat_rows_reg);
    assign tw = {rw_reg, qw_reg[12]};
    assign th = {rh_reg, qh_reg[12]};

    always_comb
    begin
        s_r = (first_reg ? '0 : rd_reg[3*SUM_W-1:2*SUM_W]) + SUM_W'(px_reg[23:16]);
        s_g = (first_reg ? '0 : rd_reg[2*SUM_W-1:SUM_W])   + SUM_W'(px_reg[15:8]);
        s_b = (first_reg ? '0 : rd_reg[SUM_W-1:0])         + SUM_W'(px_reg[7:0]);
    end

    assign cell_valid = (state_reg == F_SUM) && last_reg;
    assign wr_en      = (state_reg == F_SUM) && !last_reg;
    assign cell_data = '{block_col: col_reg, block_row: row_reg, sum_red: s_r,
                         sum_green: s_g, sum_blue: s_b, count: cnt_reg,
                         frame_done: done_reg};

    always_ff @(posedge clk)
    begin
        cnt_reg <= CNT_W'(cell_w_reg * cell_h_reg);
        if (accept)
        begin
            rd_reg    <= mem[bx_reg[AW-1:0]];
            addr_reg  <= bx_reg[AW-1:0];
            px_reg    <= {pix.red_in, pix.green_in, pix.blue_in};
            first_reg <= (cx_reg == 13'd0) && (cy_reg == 13'd0);
            last_reg  <= (cx_reg == cell_w_reg - 13'd1) && (cy_reg == cell_h_reg - 13'd1);
            done_reg  <= (bx_reg == lat_cols_reg - 13'd1) && (by_reg == lat_rows_reg - 13'd1);
            col_reg   <= bx_reg[COL_W-1:0];
            row_reg   <= by_reg[ROW_W-1:0];
        end
        if (wr_en)
            mem[addr_reg] <= {s_r, s_g, s_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_PIX;
            latched_reg  <= 1'b0;
            step_reg     <= '0;
            qw_reg <= '0; qh_reg <= '0; rw_reg <= '0; rh_reg <= '0;
            dw_reg <= 13'd1; dh_reg <= 13'd1;
            lat_fw_reg   <= 13'd1;
            lat_fh_reg   <= 13'd1;
            lat_cols_reg <= 13'd1;
            lat_rows_reg <= 13'd1;
            cell_w_reg   <= 13'd1;
            cell_h_reg   <= 13'd1;
            x_reg <= '0; y_reg <= '0; cx_reg <= '0; cy_reg <= '0;
            bx_reg <= '0; by_reg <= '0;
        end
        else
        begin
            case (state_reg)
                F_PIX:
                begin
                    if (pix.valid && start && !latched_reg)
                    begin
                        state_reg    <= F_DIV;
                        step_reg     <= '0;
                        qw_reg       <= fw_c;
                        qh_reg       <= fh_c;
                        rw_reg       <= '0;
                        rh_reg       <= '0;
                        dw_reg       <= {2'b00, ba_c};
                        dh_reg       <= bd_c;
                        lat_fw_reg   <= fw_c;
                        lat_fh_reg   <= fh_c;
                        lat_cols_reg <= ({2'b00, ba_c} < fw_c) ? {2'b00, ba_c} : fw_c;
                        lat_rows_reg <= (bd_c < fh_c) ? bd_c : fh_c;
                    end
                    else if (accept)
                    begin
                        if (active)
                            state_reg <= F_SUM;
                        if (x_reg + 13'd1 >= lat_fw_reg)
                        begin
                            x_reg  <= '0;
                            cx_reg <= '0;
                            bx_reg <= '0;
                            if (y_reg + 13'd1 >= lat_fh_reg)
                            begin
                                y_reg <= '0; cy_reg <= '0; by_reg <= '0;
                                latched_reg <= 1'b0;
                            end
                            else
                            begin
                                y_reg <= y_reg + 13'd1;
                                if (cy_reg == cell_h_reg - 13'd1)
                                begin
                                    cy_reg <= '0;
                                    by_reg <= by_reg + 13'd1;
                                end
                                else
                                    cy_reg <= cy_reg + 13'd1;
                            end
                        end
                        else
                        begin
                            x_reg <= x_reg + 13'd1;
                            if (cx_reg == cell_w_reg - 13'd1)
                            begin
                                cx_reg <= '0;
                                bx_reg <= bx_reg + 13'd1;
                            end
                            else
                                cx_reg <= cx_reg + 13'd1;
                        end
                    end
                end
                F_DIV:
                begin
                    if (tw >= {1'b0, dw_reg})
                    begin
                        rw_reg <= 13'(tw - {1'b0, dw_reg});
                        qw_reg <= {qw_reg[11:0], 1'b1};
                    end
                    else
                    begin
                        rw_reg <= tw[12:0];
                        qw_reg <= {qw_reg[11:0], 1'b0};
                    end
                    if (th >= {1'b0, dh_reg})
                    begin
                        rh_reg <= 13'(th - {1'b0, dh_reg});
                        qh_reg <= {qh_reg[11:0], 1'b1};
                    end
                    else
                    begin
                        rh_reg <= th[12:0];
                        qh_reg <= {qh_reg[11:0], 1'b0};
                    end
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd13)
                    begin
                        cell_w_reg  <= (qw_reg == 13'd0) ? 13'd1 : qw_reg;
                        cell_h_reg  <= (qh_reg == 13'd0) ? 13'd1 : qh_reg;
                        latched_reg <= 1'b1;
                        state_reg   <= F_PIX;
                    end
                end
                F_SUM:
                begin
                    if (!last_reg || cell_ready)
                        state_reg <= F_PIX;
                end
                default: state_reg <= F_PIX;
            endcase
        end
    end

endmodule

[src/mba_queue.sv]
// Two-entry queue of finished cell sums between front and back end.
module mba_queue
    import mba_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cell_t wr_data,
    input  logic  wr_valid,
    output logic  wr_ready,
    output cell_t rd_data,
    output logic  rd_valid,
    input  logic  rd_ready
);

    cell_t      slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = slot_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[src/mba_back.sv]
// Back end: divides the three channel sums by the cell pixel count, holds the result.
module mba_back
    import mba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_t     cell_data,
    input  logic      cell_valid,
    output logic      cell_ready,
    mba_res_if.source res
);

    back_state_t      state_reg;
    logic [4:0]       step_reg;
    logic [CNT_W-1:0] div_reg;
    logic [SUM_W-1:0] q_reg [3];
    logic [CNT_W-1:0] r_reg [3];
    logic [CNT_W:0]   t [3];
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             done_reg;

    assign cell_ready     = (state_reg == B_IDLE);
    assign res.valid      = (state_reg == B_OUT);
    assign res.block_col  = col_reg;
    assign res.block_row  = row_reg;
    assign res.avg_red    = q_reg[0][PIX_W-1:0];
    assign res.avg_green  = q_reg[1][PIX_W-1:0];
    assign res.avg_blue   = q_reg[2][PIX_W-1:0];
    assign res.frame_done = done_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            t[i] = {r_reg[i], q_reg[i][SUM_W-1]};
    end

    always_ff @(posedge clk)
    begin
        if (cell_valid && cell_ready)
        begin
            q_reg[0] <= cell_data.sum_red;
            q_reg[1] <= cell_data.sum_green;
            q_reg[2] <= cell_data.sum_blue;
            for (int i = 0; i < 3; i++)
                r_reg[i] <= '0;
            div_reg  <= cell_data.count;
            col_reg  <= cell_data.block_col;
            row_reg  <= cell_data.block_row;
            done_reg <= cell_data.frame_done;
        end
        else if (state_reg == B_DIV)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (t[i] >= {1'b0, div_reg})
                begin
                    r_reg[i] <= CNT_W'(t[i] - {1'b0, div_reg});
                    q_reg[i] <= {q_reg[i][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    r_reg[i] <= t[i][CNT_W-1:0];
                    q_reg[i] <= {q_reg[i][SUM_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (cell_valid)
                    begin
                        state_reg <= B_DIV;
                        step_reg  <= '0;
                    end
                end
                B_DIV:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd31)
                        state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (res.ready)
                        state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

[src/mosaic_block_average_unit.sv]
// Top level of the mosaic block averager.
//
// pix: RGB pixels of a frame in raster order, valid/ready.
// res: one item per finished mosaic cell: column, row, truncated channel means,
//      frame_done on the last cell of the frame.
// cfg: register writes (0 frame_width, 1 frame_height, 2 blocks_across,
//      3 blocks_down); always ready, applied at the next frame start.
// At the first pixel of a frame the cell size is divided out before that
// pixel is taken. Other pixels pass F_PIX only outside the cell grid, and
// F_PIX then F_SUM inside it (column sum memory read, then write).
// A finished cell goes to a two-entry queue; the back end divides its sums
// by the pixel count and takes the next cell only once its result has
// been taken, so the divider bounds the sustained rate of finished cells.
// When res stalls, the result is held, the queue fills, then pix ready drops.
// Reset returns the registers to 640x480 with 40x30 cells and makes the
// next pixel a frame start; no clearing pass is needed.
module mosaic_block_average_unit
    import mba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mba_pix_if.sink   pix,
    mba_cfg_if.sink   cfg,
    mba_res_if.source res
);

    cell_t f_cell, q_cell;
    logic  f_valid, f_ready, q_valid, q_ready;

    mba_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix),
        .cfg        (cfg),
        .cell_data  (f_cell),
        .cell_valid (f_valid),
        .cell_ready (f_ready)
    );

    mba_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (f_cell),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .rd_data  (q_cell),
        .rd_valid (q_valid),
        .rd_ready (q_ready)
    );

    mba_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_data  (q_cell),
        .cell_valid (q_valid),
        .cell_ready (q_ready),
        .res        (res)
    );

endmodule

[dv/mosaic_block_average_unit_tb.sv]
// Testbench for mosaic_block_average_unit: a table of directed items, then random frames,
// with results checked against a cell-average predictor.
module mosaic_block_average_unit_tb;
    import mba_pkg::*;

    typedef struct {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic             done;
    } cell_avg_t;

    typedef struct {
        bit               is_reg;
        logic [IDX_W-1:0] idx;
        logic [12:0]      val;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        bit               typed;
        cell_avg_t        want;
    } script_row_t;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 50;
    localparam int RAND_PIXELS = 1350;
    localparam int WIDE_PIXELS = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mba_pix_if pix ();
    mba_cfg_if cfg ();
    mba_res_if res ();

    mosaic_block_average_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .cfg   (cfg),
        .res   (res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    int unsigned reg_fw, reg_fh, reg_ba, reg_bd;
    int unsigned px, py, cw, ch, lat_fw, lat_fh, lat_cols, lat_rows;
    int unsigned red_acc [1024];
    int unsigned green_acc [1024];
    int unsigned blue_acc [1024];

    cell_avg_t pending_cells[$];
    int        errors = 0;
    int        cycles = 0;
    bit        pix_up = 1'b0;
    bit        tx_idle = 1'b1;
    bit        rx_idle = 1'b1;
    int        rx_hold = 0;

    function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic bit average_pixel(input logic [7:0] r, g, b, output cell_avg_t c);
        int unsigned ba, bd, bx, by, n;
        bit          hit;
        hit = 1'b0;
        c = '{default: '0};
        if (px == 0 && py == 0)
        begin
            ba = clamp(reg_ba, 1, 1024);
            bd = clamp(reg_bd, 1, BLOCKS_DOWN_MAX);
            lat_fw = clamp(reg_fw, 1, 4096);
            lat_fh = clamp(reg_fh, 1, 4096);
            cw = (lat_fw / ba < 1) ? 1 : lat_fw / ba;
            ch = (lat_fh / bd < 1) ? 1 : lat_fh / bd;
            lat_cols = (ba < lat_fw) ? ba : lat_fw;
            lat_rows = (bd < lat_fh) ? bd : lat_fh;
        end
        bx = px / cw;
        by = py / ch;
        if (bx < lat_cols && by < lat_rows && bx < 1024)
        begin
            red_acc[bx] += r;
            green_acc[bx] += g;
            blue_acc[bx] += b;
            if (px % cw == cw - 1 && py % ch == ch - 1)
            begin
                n = cw * ch;
                c.col = bx[COL_W-1:0];
                c.row = by[ROW_W-1:0];
                c.red = 8'(red_acc[bx] / n);
                c.green = 8'(green_acc[bx] / n);
                c.blue = 8'(blue_acc[bx] / n);
                c.done = (bx == lat_cols - 1 && by == lat_rows - 1);
                red_acc[bx] = 0;
                green_acc[bx] = 0;
                blue_acc[bx] = 0;
                hit = 1'b1;
            end
        end
        px++;
        if (px >= lat_fw)
        begin
            px = 0;
            py++;
            if (py >= lat_fh)
                py = 0;
        end
        return hit;
    endfunction

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        errors++;
        $display("[%0d] %s: got %0d, want %0d", cycles, what, got, want);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [12:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            REG_FRAME_WIDTH:   reg_fw = val;
            REG_FRAME_HEIGHT:  reg_fh = val;
            REG_BLOCKS_ACROSS: reg_ba = val[10:0];
            REG_BLOCKS_DOWN:   reg_bd = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        if (pix_up)
        begin
            pix.valid <= 1'b0;
            pix_up = 1'b0;
        end
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // typed expectation overrides the predictor's when given
    task automatic send_pixel(input logic [7:0] r, g, b, input bit typed, input cell_avg_t want);
        int        gap;
        cell_avg_t c;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            if (pix_up)
                pix.valid <= 1'b0;
            pix_up = 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid    <= 1'b1;
        pix.red_in   <= r;
        pix.green_in <= g;
        pix.blue_in  <= b;
        pix_up = 1'b1;
        do @(posedge clk); while (!pix.ready);
        if (average_pixel(r, g, b, c))
            pending_cells.push_back(typed ? want : c);
    endtask

    task automatic send_random_pixel();
        logic [7:0] r, g, b;
        if ($urandom_range(0, 5) == 0)
        begin
            r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        else
        begin
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
        end
        send_pixel(r, g, b, 1'b0, '{default: '0});
    endtask

    // result side
    initial
    begin
        cell_avg_t w;
        int        gap_left;
        gap_left = 0;
        res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res.ready && res.valid)
            begin
                if (pending_cells.size() == 0)
                    report("unexpected cell, block_col", res.block_col, 0);
                else
                begin
                    w = pending_cells.pop_front();
                    if (res.block_col !== w.col) report("block_col", res.block_col, w.col);
                    if (res.block_row !== w.row) report("block_row", res.block_row, w.row);
                    if (res.avg_red !== w.red) report("avg_red", res.avg_red, w.red);
                    if (res.avg_green !== w.green) report("avg_green", res.avg_green, w.green);
                    if (res.avg_blue !== w.blue) report("avg_blue", res.avg_blue, w.blue);
                    if (res.frame_done !== w.done)
                        report("frame_done", res.frame_done, w.done);
                end
                gap_left = rx_idle ? $urandom_range(0, 7) : 0;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                res.ready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                res.ready <= 1'b0;
            end
            else
                res.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    script_row_t script [14];

    initial
    begin
        int          sent, target, ph;
        int unsigned fw, fh;
        pix.valid = 1'b0;
        pix.red_in = '0;
        pix.green_in = '0;
        pix.blue_in = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        reg_fw = RST_FRAME_WIDTH;
        reg_fh = RST_FRAME_HEIGHT;
        reg_ba = RST_BLOCKS_ACROSS;
        reg_bd = RST_BLOCKS_DOWN;
        px = 0; py = 0; cw = 1; ch = 1;
        lat_fw = 1; lat_fh = 1; lat_cols = 1; lat_rows = 1;
        foreach (red_acc[i])
        begin
            red_acc[i] = 0;
            green_acc[i] = 0;
            blue_acc[i] = 0;
        end
        script = '{
            '{1, REG_FRAME_WIDTH,   13'd2, 0, 0, 0, 0, '{default: '0}},
            '{1, REG_FRAME_HEIGHT,  13'd1, 0, 0, 0, 0, '{default: '0}},
            '{1, REG_BLOCKS_ACROSS, 13'd2, 0, 0, 0, 0, '{default: '0}},
            '{1, REG_BLOCKS_DOWN,   13'd1, 0, 0, 0, 0, '{default: '0}},
            '{0, REG_FRAME_WIDTH, 0, 8'hFF, 8'hFF, 8'hFF, 1, '{0, 0, 8'hFF, 8'hFF, 8'hFF, 0}},
            '{0, REG_FRAME_WIDTH, 0, 8'h00, 8'h00, 8'h00, 1, '{1, 0, 8'h00, 8'h00, 8'h00, 1}},
            '{0, REG_FRAME_WIDTH, 0, 8'hAA, 8'h55, 8'h0F, 1, '{0, 0, 8'hAA, 8'h55, 8'h0F, 0}},
            '{0, REG_FRAME_WIDTH, 0, 8'h55, 8'hAA, 8'hF0, 1, '{1, 0, 8'h55, 8'hAA, 8'hF0, 1}},
            // zero sizes clamp to a single-pixel frame
            '{1, REG_FRAME_WIDTH,   13'd0, 0, 0, 0, 0, '{default: '0}},
            '{1, REG_FRAME_HEIGHT,  13'd0, 0, 0, 0, 0, '{default: '0}},
            '{1, REG_BLOCKS_ACROSS, 13'd0, 0, 0, 0, 0, '{default: '0}},
            '{1, REG_BLOCKS_DOWN,   13'd0, 0, 0, 0, 0, '{default: '0}},
            '{0, REG_FRAME_WIDTH, 0, 8'h01, 8'h02, 8'h03, 1, '{0, 0, 8'h01, 8'h02, 8'h03, 1}},
            '{0, REG_FRAME_WIDTH, 0, 8'h80, 8'h40, 8'hC8, 1, '{0, 0, 8'h80, 8'h40, 8'hC8, 1}}
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_reg)
            begin
                if (i == 0 || !script[i-1].is_reg)
                    drain();
                write_reg(script[i].idx, script[i].val);
                if (i == $size(script) - 1 || !script[i+1].is_reg)
                    cfg.valid <= 1'b0;
            end
            else
                send_pixel(script[i].red, script[i].green, script[i].blue,
                           script[i].typed, script[i].want);
        end
        drain();

        sent = 0;
        ph = 0;
        while (sent < RAND_PIXELS)
        begin
            fw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
            fh = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            write_reg(REG_FRAME_WIDTH, 13'(fw));
            write_reg(REG_FRAME_HEIGHT, 13'(fh));
            write_reg(REG_BLOCKS_ACROSS,
                      ($urandom_range(0, 9) == 0) ? 13'd2047 : 13'($urandom_range(0, fw + 3)));
            write_reg(REG_BLOCKS_DOWN,
                      ($urandom_range(0, 9) == 0) ? 13'd8191 : 13'($urandom_range(0, fh + 3)));
            // one cell per pixel so the long receiver stall backs up to the input
            if (ph == 2)
            begin
                write_reg(REG_FRAME_WIDTH,   13'd4);
                write_reg(REG_FRAME_HEIGHT,  13'd4);
                write_reg(REG_BLOCKS_ACROSS, 13'd4);
                write_reg(REG_BLOCKS_DOWN,   13'd4);
            end
            cfg.valid <= 1'b0;
            tx_idle = ($urandom_range(0, 2) != 0);
            rx_idle = ($urandom_range(0, 2) != 0);
            if (ph == 2)
                rx_hold = 400;
            target = $urandom_range(20, 150);
            for (int k = 0; k < target || !(px == 0 && py == 0); k++)
            begin
                send_random_pixel();
                sent++;
            end
            drain();
            ph++;
        end

        // oversize values clamp: 4096 wide, 1024 cells across
        write_reg(REG_FRAME_WIDTH,   13'd8191);
        write_reg(REG_FRAME_HEIGHT,  13'd1);
        write_reg(REG_BLOCKS_ACROSS, 13'd2047);
        write_reg(REG_BLOCKS_DOWN,   13'd8191);
        cfg.valid <= 1'b0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        for (int k = 0; k < WIDE_PIXELS; k++)
            send_random_pixel();
        drain();

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
